// ===== hw/rtl/lag_pkg.sv =====
// ============================================================================
// lag_pkg
// Shared types and constants for the bounded-grid life automaton.
// ============================================================================
package lag_pkg;

  // Grid edge length in cells (valid range 3 to 32)
  localparam int GRID_DIM = 32;
  localparam int IDX_W    = $clog2(GRID_DIM);

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 5;
  localparam int GEN_W    = 16;

  // Input word: cmd, cell_col, cell_row, alive_in, padded to whole bytes
  localparam int IN_BITS  = CMD_W + 2 * COORD_W + 1;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  // Output word: alive_out, generation, padded to whole bytes
  localparam int OUT_BITS = 1 + GEN_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Survival and birth neighbor counts
  localparam logic [3:0] KEEP_LO = 4'd2;
  localparam logic [3:0] BIRTH_N = 4'd3;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               alive_in;
  } lag_cmd_t;

  typedef struct packed {
    logic             alive_out;
    logic [GEN_W-1:0] generation;
  } lag_rsp_t;

endpackage

// ===== hw/rtl/lag_cell.sv =====
// ============================================================================
// lag_cell
// One grid cell: state flop plus neighbor count and life rule.
// ============================================================================
module lag_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] nbr,
  input  logic       step,
  input  logic       wr_en,
  input  logic       wr_val,
  output logic       alive
);

  logic [3:0] count;
  logic       rule_next;
  logic       alive_next;

  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      count = count + {3'd0, nbr[i]};
    end
  end

  assign rule_next = (count == lag_pkg::BIRTH_N) || (alive && (count == lag_pkg::KEEP_LO));

  always_comb begin
    alive_next = alive;
    if (step) begin
      alive_next = rule_next;
    end else if (wr_en) begin
      alive_next = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else begin
      alive <= alive_next;
    end
  end

endmodule

// ===== hw/rtl/lag_grid.sv =====
// ============================================================================
// lag_grid
// Cell array, generation counter and command execution.
// ============================================================================
module lag_grid (
  input  logic              clk,
  input  logic              rst,
  input  logic              exec,
  input  lag_pkg::lag_cmd_t op,
  output lag_pkg::lag_rsp_t rsp
);

  localparam int N = lag_pkg::GRID_DIM;

  logic [N-1:0]              grid [N];
  logic [lag_pkg::GEN_W-1:0] generation;
  logic [lag_pkg::GEN_W-1:0] generation_next;
  logic                      in_grid;
  logic [lag_pkg::IDX_W-1:0] col_idx;
  logic [lag_pkg::IDX_W-1:0] row_idx;
  logic                      do_step;
  logic                      do_write;

  assign in_grid  = (32'(op.cell_col) < N) && (32'(op.cell_row) < N);
  assign col_idx  = lag_pkg::IDX_W'(op.cell_col);
  assign row_idx  = lag_pkg::IDX_W'(op.cell_row);
  assign do_step  = exec && (op.cmd == lag_pkg::CMD_STEP);
  assign do_write = exec && (op.cmd == lag_pkg::CMD_WRITE) && in_grid;

  assign generation_next = do_step ? generation + 1'b1 : generation;

  always_ff @(posedge clk) begin
    if (rst) begin
      generation <= '0;
    end else begin
      generation <= generation_next;
    end
  end

  // Cells beyond the edge count as dead
  for (genvar c = 0; c < N; c++) begin : g_col
    for (genvar r = 0; r < N; r++) begin : g_row
      logic [7:0] nbr;
      logic       wr_hit;

      assign nbr[0] = (c > 0     && r > 0    ) ? grid[(c > 0) ? c-1 : 0][(r > 0) ? r-1 : 0] : 1'b0;
      assign nbr[1] = (c > 0                 ) ? grid[(c > 0) ? c-1 : 0][r]                 : 1'b0;
      assign nbr[2] = (c > 0     && r < N-1  ) ? grid[(c > 0) ? c-1 : 0][(r < N-1) ? r+1 : r] : 1'b0;
      assign nbr[3] = (r > 0                 ) ? grid[c][(r > 0) ? r-1 : 0]                 : 1'b0;
      assign nbr[4] = (r < N-1               ) ? grid[c][(r < N-1) ? r+1 : r]               : 1'b0;
      assign nbr[5] = (c < N-1   && r > 0    ) ? grid[(c < N-1) ? c+1 : c][(r > 0) ? r-1 : 0] : 1'b0;
      assign nbr[6] = (c < N-1               ) ? grid[(c < N-1) ? c+1 : c][r]               : 1'b0;
      assign nbr[7] = (c < N-1   && r < N-1  ) ? grid[(c < N-1) ? c+1 : c][(r < N-1) ? r+1 : r] : 1'b0;

      assign wr_hit = do_write && (col_idx == lag_pkg::IDX_W'(c)) && (row_idx == lag_pkg::IDX_W'(r));

      lag_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .nbr    (nbr),
        .step   (do_step),
        .wr_en  (wr_hit),
        .wr_val (op.alive_in),
        .alive  (grid[c][r])
      );
    end
  end

  assign rsp.alive_out  = (op.cmd == lag_pkg::CMD_READ) && in_grid && grid[col_idx][row_idx];
  assign rsp.generation = generation_next;

endmodule

// ===== hw/rtl/life_automaton_grid_core.sv =====
// ============================================================================
// life_automaton_grid_core
// Bounded-grid life automaton with a streaming command and result port.
// ============================================================================
// The block keeps a GRID_DIM x GRID_DIM grid of one-bit cells, all dead after
// reset, and treats everything beyond the edges as dead. Each input word is
// one command: write one cell, read one cell, or advance the whole grid one
// generation (a live cell survives with two or three live neighbors, a dead
// one comes alive with exactly three). Every command returns exactly one
// result word carrying the read value (zero unless it was a read of a cell
// inside the grid) and the generation count after the command. An unused
// command code changes nothing. Each cell has its own flop and rule logic, so
// every command completes in the execute stage; with an input register and an
// output register around it, a new word is taken every cycle as long as the
// result side keeps up.
module life_automaton_grid_core (
  input  logic                      clk,
  input  logic                      rst,
  // s_tdata: [1:0] cmd, [6:2] cell_col, [11:7] cell_row, [12] alive_in, rest zero
  input  logic [lag_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // m_tdata: [0] alive_out, [16:1] generation, rest zero
  output logic [lag_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready
);

  lag_pkg::lag_cmd_t op;
  lag_pkg::lag_cmd_t op_next;
  lag_pkg::lag_rsp_t rsp;
  logic              op_valid;
  logic              advance;
  logic              exec;

  // Move the execute stage whenever the output register is free or draining
  assign advance  = !m_tvalid || m_tready;
  assign exec     = op_valid && advance;
  assign s_tready = !op_valid || advance;

  // Unpack the input word, lowest field first
  assign op_next.cmd      = s_tdata[1:0];
  assign op_next.cell_col = s_tdata[6:2];
  assign op_next.cell_row = s_tdata[11:7];
  assign op_next.alive_in = s_tdata[12];

  // Input register: hold the command until the execute stage can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (s_tready) begin
      op_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      op <= op_next;
    end
  end

  // Execute: the grid updates in the same edge that captures the result
  lag_grid u_grid (
    .clk  (clk),
    .rst  (rst),
    .exec (exec),
    .op   (op),
    .rsp  (rsp)
  );

  // Output register: hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      m_tdata <= {(lag_pkg::OUT_W - lag_pkg::OUT_BITS)'(0), rsp.generation, rsp.alive_out};
    end
  end

endmodule

// ===== verif/lag_grid_checker.sv =====
// ============================================================================
// lag_grid_checker
// Watches both stream ports of the life automaton, keeps its own copy of the
// grid and the generation count, and checks every result word against it.
// ============================================================================
module lag_grid_checker
  import lag_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic            m_tvalid,
  input  logic            m_tready,
  output int              mismatches,
  output int              replies_owed,
  output int              replies_checked
);

  typedef struct packed {
    logic             alive;
    logic [GEN_W-1:0] gen;
  } cell_reply_t;

  // grid_col[c][r] is the cell at column c, row r
  logic [GRID_DIM-1:0] grid_col [GRID_DIM];
  logic [GEN_W-1:0]    gen_count;
  cell_reply_t         reply_q [$];

  initial begin
    mismatches      = 0;
    replies_owed    = 0;
    replies_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Cells beyond the edge read as dead
  function automatic logic cell_live(input int c, input int r);
    if (c < 0 || c >= GRID_DIM || r < 0 || r >= GRID_DIM) begin
      return 1'b0;
    end
    return grid_col[c][r];
  endfunction

  // Build the whole next generation from the current one, then swap it in
  task automatic advance_grid();
    logic [GRID_DIM-1:0] nxt [GRID_DIM];
    int                  n;
    logic                live;
    for (int c = 0; c < GRID_DIM; c++) begin
      for (int r = 0; r < GRID_DIM; r++) begin
        n = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          for (int dr = -1; dr <= 1; dr++) begin
            if (dc != 0 || dr != 0) begin
              n += int'(cell_live(c + dc, r + dr));
            end
          end
        end
        live      = grid_col[c][r];
        nxt[c][r] = live ? (n == 2 || n == 3) : (n == 3);
      end
    end
    grid_col  = nxt;
    gen_count = gen_count + 1'b1;
  endtask

  task automatic apply_command(input logic [IN_W-1:0] word);
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               alive;
    logic               on_grid;
    cell_reply_t        rep;
    cmd     = word[1:0];
    col     = word[6:2];
    row     = word[11:7];
    alive   = word[12];
    on_grid = (int'(col) < GRID_DIM) && (int'(row) < GRID_DIM);
    rep     = '0;
    case (cmd)
      CMD_WRITE: begin
        if (on_grid) begin
          grid_col[col][row] = alive;
        end
      end
      CMD_READ: begin
        if (on_grid) begin
          rep.alive = grid_col[col][row];
        end
      end
      CMD_STEP: begin
        advance_grid();
      end
      default: begin
        // unused code: no state change
      end
    endcase
    rep.gen = gen_count;
    reply_q.push_back(rep);
  endtask

  always @(posedge clk) begin
    cell_reply_t want;
    if (rst) begin
      foreach (grid_col[c]) begin
        grid_col[c] = '0;
      end
      gen_count = '0;
      reply_q.delete();
    end else begin
      // Predict first, so a reply in the same cycle as its command would still find its entry
      if (s_tvalid && s_tready) begin
        apply_command(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result word %0h with nothing expected", m_tdata));
        end else begin
          want = reply_q.pop_front();
          replies_checked++;
          if (m_tdata[0] !== want.alive) begin
            report_mismatch($sformatf("alive_out expected %0b got %0b",
                                      want.alive, m_tdata[0]));
          end
          if (m_tdata[16:1] !== want.gen) begin
            report_mismatch($sformatf("generation expected %0d got %0d",
                                      want.gen, m_tdata[16:1]));
          end
          if (m_tdata[OUT_W-1:17] !== '0) begin
            report_mismatch($sformatf("padding bits not zero: %0h",
                                      m_tdata[OUT_W-1:17]));
          end
        end
      end
    end
    replies_owed = reply_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Drives commands into life_automaton_grid_core and delivers the verdict.
// ============================================================================
// A directed opening covers the grid corners and edges, still lifes and
// oscillators touching the border, clearing a cell and the unused command
// code. The random part mostly builds small patterns in a window placed
// anywhere on the grid (edges included), steps them and reads them back,
// with some fully random commands mixed in. Both ports idle in random bursts
// except during the final stretch. lag_grid_checker does all the checking.
module tb_top;
  import lag_pkg::*;

  localparam int TOTAL_ITEMS  = 850;
  localparam int QUIET_TAIL   = 120;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tvalid;
  logic             m_tready = 1'b0;

  int mismatches;
  int replies_owed;
  int replies_checked;
  int idle_cycles = 0;
  int items_sent  = 0;
  int cmd_tally [4] = '{0, 0, 0, 0};
  bit bursts_on   = 1'b1;

  always #1 clk = ~clk;

  life_automaton_grid_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  lag_grid_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_tdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .mismatches      (mismatches),
    .replies_owed    (replies_owed),
    .replies_checked (replies_checked)
  );

  // Count cycles in which no word moves on either port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no word moved for %0d cycles, %0d results owed",
             STALL_LIMIT, replies_owed);
    $display("life_automaton_grid_core test failed");
    $finish;
  end

  // Result side: accept by default, stall in random bursts while allowed
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && bursts_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Present one command word and hold it until taken. Entered and left at a
  // falling edge; valid stays high between back-to-back words.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] col,
                          input logic [COORD_W-1:0] row, input logic alive);
    logic [IN_W-1:0] word;
    word        = '0;
    word[1:0]   = cmd;
    word[6:2]   = col;
    word[11:7]  = row;
    word[12]    = alive;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    cmd_tally[cmd]++;
    items_sent++;
    if (items_sent > TOTAL_ITEMS - QUIET_TAIL) begin
      bursts_on = 1'b0;
    end
  endtask

  // Seed a small pattern in an 8x8 window, then step and probe it
  task automatic pattern_burst();
    int wc;
    int wr;
    int pick;
    pick = $urandom_range(0, 3);
    wc   = (pick == 0) ? 0 : (pick == 1) ? 24 : $urandom_range(0, 24);
    pick = $urandom_range(0, 3);
    wr   = (pick == 0) ? 0 : (pick == 1) ? 24 : $urandom_range(0, 24);
    repeat ($urandom_range(4, 14)) begin
      send_cmd(CMD_WRITE, COORD_W'(wc + $urandom_range(0, 7)),
               COORD_W'(wr + $urandom_range(0, 7)), $urandom_range(0, 9) < 7);
    end
    repeat ($urandom_range(1, 4)) begin
      send_cmd(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 4)) begin
        send_cmd(CMD_READ, COORD_W'(wc + $urandom_range(0, 7)),
                 COORD_W'(wr + $urandom_range(0, 7)), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fresh grid reads dead at opposite corners
    send_cmd(CMD_READ,  5'd0,  5'd0,  1'b1);
    send_cmd(CMD_READ,  5'd31, 5'd31, 1'b0);
    // L-shape in the top-left corner grows into a block
    send_cmd(CMD_WRITE, 5'd0,  5'd0,  1'b1);
    send_cmd(CMD_WRITE, 5'd1,  5'd0,  1'b1);
    send_cmd(CMD_WRITE, 5'd0,  5'd1,  1'b1);
    // Same in the far corner, so neighbors past both high edges matter
    send_cmd(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    send_cmd(CMD_WRITE, 5'd30, 5'd31, 1'b1);
    send_cmd(CMD_WRITE, 5'd31, 5'd30, 1'b1);
    // Blinker lying along the top edge: half of it falls off the grid
    send_cmd(CMD_WRITE, 5'd10, 5'd0,  1'b1);
    send_cmd(CMD_WRITE, 5'd11, 5'd0,  1'b1);
    send_cmd(CMD_WRITE, 5'd12, 5'd0,  1'b1);
    send_cmd(CMD_STEP,  5'd31, 5'd31, 1'b1);
    send_cmd(CMD_READ,  5'd1,  5'd1,  1'b0);
    send_cmd(CMD_READ,  5'd30, 5'd30, 1'b1);
    send_cmd(CMD_READ,  5'd11, 5'd1,  1'b0);
    send_cmd(CMD_READ,  5'd10, 5'd0,  1'b0);
    // Unused command code with every other bit set: nothing may change
    send_cmd(2'd3,      5'd31, 5'd31, 1'b1);
    send_cmd(CMD_READ,  5'd31, 5'd31, 1'b0);
    // Kill a corner cell, then step twice
    send_cmd(CMD_WRITE, 5'd0,  5'd0,  1'b0);
    send_cmd(CMD_READ,  5'd0,  5'd0,  1'b0);
    send_cmd(CMD_STEP,  5'd0,  5'd0,  1'b0);
    send_cmd(CMD_STEP,  5'd0,  5'd0,  1'b0);
    send_cmd(CMD_READ,  5'd0,  5'd0,  1'b1);

    // Mostly well-formed pattern bursts, some raw random commands
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        pattern_burst();
      end else begin
        send_cmd(CMD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 1'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    // Hold until every result is back, then let the pipe run dry
    while (replies_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d writes, %0d reads, %0d generation steps, %0d unused",
             items_sent, cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3]);
    $display("checked %0d result words, %0d mismatches", replies_checked, mismatches);
    if (mismatches == 0) begin
      $display("life_automaton_grid_core test passed");
    end else begin
      $display("life_automaton_grid_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lag_pkg.sv
hw/rtl/lag_cell.sv
hw/rtl/lag_grid.sv
hw/rtl/life_automaton_grid_core.sv
verif/lag_grid_checker.sv
verif/tb_top.sv
